>>> rtl/core/lftc_pkg.sv
// Package of types and constants shared by the LED fade toggle controller.
`default_nettype none

package lftc_pkg;

  localparam int unsigned STEP_W    = 16;
  localparam int unsigned TIMEOUT_W = 24;
  localparam int unsigned ELAPSED_W = 24;
  localparam int unsigned CMP_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMED_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIMEOUT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [STEP_W-1:0]    MANUAL_STEP_RST = 16'd19;
  localparam logic [STEP_W-1:0]    TIMED_STEP_RST  = 16'd14117;
  localparam logic [TIMEOUT_W-1:0] OFF_TIMEOUT_RST = 24'd14400000;

  typedef struct packed {
    logic tick;
    logic press;
  } in_t;

  typedef struct packed {
    logic [CMP_W-1:0] compare_level;
    logic             lamp_on;
    logic             fading;
  } out_t;

  typedef struct packed {
    logic [STEP_W-1:0]    manual_step_ms;
    logic [STEP_W-1:0]    timed_step_ms;
    logic [TIMEOUT_W-1:0] off_timeout_ms;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/lftc_cfg_regs.sv
// Configuration register bank of the LED fade toggle controller.
`default_nettype none

module lftc_cfg_regs
  import lftc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [TIMEOUT_W-1:0] wr_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.manual_step_ms <= MANUAL_STEP_RST;
      cfg_r.timed_step_ms  <= TIMED_STEP_RST;
      cfg_r.off_timeout_ms <= OFF_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_MANUAL_STEP: cfg_r.manual_step_ms <= wr_data[STEP_W-1:0];
        CFG_TIMED_STEP:  cfg_r.timed_step_ms  <= wr_data[STEP_W-1:0];
        CFG_OFF_TIMEOUT: cfg_r.off_timeout_ms <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/lftc_fade_core.sv
// Fade state registers and their single-pass next-state logic.
`default_nettype none

module lftc_fade_core
  import lftc_pkg::*;
#(
  parameter int unsigned LEVEL_MAX = 255
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  wire in_t  item,
  input  wire cfg_t cfg,
  output out_t      result
);

  localparam int unsigned LVL_W = $clog2(LEVEL_MAX + 1);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVEL_MAX);

  logic [LVL_W-1:0]     level_r, level_nxt;
  logic                 settled_on_r, settled_on_nxt;
  logic                 in_fade_r, in_fade_nxt;
  logic                 fade_to_off_r, fade_to_off_nxt;
  logic                 slow_rate_r, slow_rate_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 counting_r, counting_nxt;

  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [ELAPSED_W-1:0] elapsed_cnt;
  logic [STEP_W-1:0]    period;
  logic [LVL_W-1:0]     level_step;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign period      = slow_rate_r ? cfg.timed_step_ms : cfg.manual_step_ms;

  always_comb begin
    level_nxt       = level_r;
    settled_on_nxt  = settled_on_r;
    in_fade_nxt     = in_fade_r;
    fade_to_off_nxt = fade_to_off_r;
    slow_rate_nxt   = slow_rate_r;
    elapsed_nxt     = elapsed_r;
    counting_nxt    = counting_r;
    elapsed_cnt     = elapsed_r;
    level_step      = level_r;

    if (in_fade_r) begin
      if (item.tick) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= ELAPSED_W'(period)) begin
          elapsed_nxt = '0;
          if (fade_to_off_r) begin
            if (level_r < LVL_MAX) level_step = level_r + 1'b1;
          end else begin
            if (level_r != '0) level_step = level_r - 1'b1;
          end
        end
        level_nxt = level_step;
        if (fade_to_off_r && (level_step >= LVL_MAX)) begin
          in_fade_nxt    = 1'b0;
          settled_on_nxt = 1'b0;
          elapsed_nxt    = '0;
        end else if (!fade_to_off_r && (level_step == '0)) begin
          in_fade_nxt    = 1'b0;
          settled_on_nxt = 1'b1;
          counting_nxt   = 1'b0;
        end
      end
    end else begin
      if (item.tick && counting_r) elapsed_cnt = elapsed_inc;
      elapsed_nxt = elapsed_cnt;
      priority if (item.press) begin
        in_fade_nxt     = 1'b1;
        fade_to_off_nxt = settled_on_r;
        slow_rate_nxt   = 1'b0;
        elapsed_nxt     = '0;
        counting_nxt    = 1'b1;
      end else if (!settled_on_r && counting_r && (elapsed_cnt >= cfg.off_timeout_ms)) begin
        in_fade_nxt     = 1'b1;
        fade_to_off_nxt = 1'b0;
        slow_rate_nxt   = 1'b1;
        elapsed_nxt     = '0;
        counting_nxt    = 1'b1;
      end else begin
        // Nothing starts a fade, so the settled state is kept.
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r       <= '0;
      settled_on_r  <= 1'b1;
      in_fade_r     <= 1'b0;
      fade_to_off_r <= 1'b0;
      slow_rate_r   <= 1'b0;
      elapsed_r     <= '0;
      counting_r    <= 1'b0;
    end else if (fire) begin
      level_r       <= level_nxt;
      settled_on_r  <= settled_on_nxt;
      in_fade_r     <= in_fade_nxt;
      fade_to_off_r <= fade_to_off_nxt;
      slow_rate_r   <= slow_rate_nxt;
      elapsed_r     <= elapsed_nxt;
      counting_r    <= counting_nxt;
    end
  end

  assign result.compare_level = CMP_W'(level_nxt);
  assign result.lamp_on       = settled_on_nxt;
  assign result.fading        = in_fade_nxt;

`ifndef SYNTHESIS
  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_MAX) else $error("fade level beyond its maximum");

  a_idle_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fade_r && settled_on_r) |-> (level_r == '0))
    else $error("lamp settled on but level not zero");

  a_idle_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fade_r && !settled_on_r) |-> (level_r == LVL_MAX))
    else $error("lamp settled off but level not at maximum");

  a_counting_idle_on: assert property (@(posedge clk) disable iff (!rst_n)
    !counting_r |-> (!in_fade_r && settled_on_r))
    else $error("counter stopped while fading or off");
`endif

endmodule

`default_nettype wire

>>> rtl/core/led_fade_toggle_controller.sv
// Top level of the LED fade toggle controller: input and result registers.
// An accepted item waits in the input register, and its result is registered in the result
// register once that register is empty or being drained; out_valid then rises.
// Throughput: one transaction per cycle unless stalled; the whole state update is one pass of the fade core.
// Reset (rst_n, synchronous, active low): lamp settled on, compare level 0, no fade,
// counter cleared, configuration registers at their default values, both stages empty.
`default_nettype none

module led_fade_toggle_controller
  import lftc_pkg::*;
#(
  parameter int unsigned LEVEL_MAX = 255
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIMEOUT_W-1:0] cfg_wdata
);

  // The input register holds one accepted transaction. It is processed by the
  // fade core, which updates the state, in the cycle in which the result
  // register can take its answer: that register is empty or being drained.
  logic  s1_valid_r;
  in_t   s1_data_r;
  logic  out_valid_r;
  out_t  out_data_r;
  logic  out_free;
  logic  s1_fire;
  logic  in_take;
  cfg_t  cfg;
  out_t  core_result;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  // The input register may refill in the same cycle in which it is emptied.
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Registers are always writable; software must write only while the block is idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  lftc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  lftc_fade_core #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_fade_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r) else $error("processed transaction lost");

  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

>>> tb/led_fade_toggle_controller_test.sv
// Self-checking testbench for the LED fade toggle controller, with driver, monitor and predictor.
`default_nettype none

module led_fade_toggle_controller_test;
  import lftc_pkg::*;

  // The block is built with its default fade ceiling, and the predictor uses the same value.
  localparam int unsigned LEVEL_TOP = 255;
  // No register sits behind the last index, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  // Several times the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_CAP = 20;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIMEOUT_W-1:0] cfg_wdata = '0;

  led_fade_toggle_controller #(
    .LEVEL_MAX(LEVEL_TOP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Shadow copy of the configuration registers, updated when a write transaction completes.
  logic [STEP_W-1:0] manual_step;
  logic [STEP_W-1:0] timed_step;
  logic [TIMEOUT_W-1:0] off_timeout;

  // Shadow copy of the dimmer state.
  int unsigned lamp_level;
  bit lamp_settled_on;
  bit fade_active;
  bit fade_to_off;
  bit fade_slow;
  logic [ELAPSED_W-1:0] elapsed_ms;
  bit ms_counting;

  // Remote events waiting to be offered, and the lamp states that accepted events must produce.
  in_t remote_events[$];
  out_t lamp_states_due[$];
  out_t lamp_want;

  int unsigned events_sent = 0;
  int unsigned states_checked = 0;
  int unsigned mismatches = 0;
  int unsigned press_fades = 0;
  int unsigned timed_fades = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;

  // Sender burst shaping.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // Receiver stall pattern and the single long hold-off.
  rx_mode_e stall_mode = RX_FREE;
  int unsigned stall_mode_left = 0;
  int unsigned holdoff_left = 0;
  bit holdoff_done = 1'b0;

  function automatic void begin_fade(input bit to_off, input bit slow);
    fade_active = 1'b1;
    fade_to_off = to_off;
    fade_slow = slow;
    elapsed_ms = '0;
    ms_counting = 1'b1;
  endfunction

  // Applies one remote event to the shadow state and returns the lamp state the block must
  // report for it. A zero step period behaves as one, because the counter has always been
  // bumped before it is compared. The counter saturates rather than wrapping.
  function automatic out_t advance_fade(input in_t ev);
    logic [STEP_W-1:0] period;
    out_t lamp;
    if (fade_active) begin
      if (ev.tick) begin
        period = fade_slow ? timed_step : manual_step;
        if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;
        if (elapsed_ms >= period) begin
          elapsed_ms = '0;
          if (fade_to_off) begin
            if (lamp_level < LEVEL_TOP) lamp_level++;
          end else if (lamp_level > 0) begin
            lamp_level--;
          end
        end
        if (fade_to_off && lamp_level >= LEVEL_TOP) begin
          // Off-fade done: the counter restarts from zero and keeps running for the timeout.
          fade_active = 1'b0;
          lamp_settled_on = 1'b0;
          elapsed_ms = '0;
        end else if (!fade_to_off && lamp_level == 0) begin
          fade_active = 1'b0;
          lamp_settled_on = 1'b1;
          ms_counting = 1'b0;
        end
      end
      // A press during a fade is simply dropped.
    end else begin
      if (ev.tick && ms_counting && elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;
      if (ev.press) begin
        // A press wins over an expired timeout, so the on-fade then runs at the manual rate.
        begin_fade(lamp_settled_on, 1'b0);
        press_fades++;
      end else if (!lamp_settled_on && ms_counting && elapsed_ms >= off_timeout) begin
        begin_fade(1'b0, 1'b1);
        timed_fades++;
      end
    end
    lamp.compare_level = lamp_level[CMP_W-1:0];
    lamp.lamp_on = lamp_settled_on;
    lamp.fading = fade_active;
    return lamp;
  endfunction

  // Driver: offers remote events in bursts with gaps between them. A stalled transaction
  // is held unchanged, and the prediction is made at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        lamp_states_due.push_back(advance_fade(in_data));
        events_sent <= events_sent + 1;
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (remote_events.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= remote_events.pop_front();
        if (burst_left <= 1) begin
          // Now and then a long burst with no gap at all.
          burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: the pattern is redrawn at random intervals, and once, after some results
  // have been checked, the receiver holds off long enough for the block to fill and stall
  // its input while the sender keeps offering.
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_mode_left == 0) begin
        stall_mode = rx_mode_e'($urandom_range(3));
        stall_mode_left = $urandom_range(20, 120);
      end else begin
        stall_mode_left--;
      end
      if (!holdoff_done && states_checked >= 150) begin
        holdoff_left = 80;
        holdoff_done = 1'b1;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          RX_FREE: out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(99) < 30);
          RX_HEAVY: out_stall <= ($urandom_range(99) < 75);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Monitor: every accepted result is checked against the oldest predicted lamp state.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lamp_states_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: result with nothing expected: level %0d on %0b fading %0b", $time,
                   out_data.compare_level, out_data.lamp_on, out_data.fading);
      end else begin
        lamp_want = lamp_states_due.pop_front();
        if (out_data.compare_level !== lamp_want.compare_level ||
            out_data.lamp_on !== lamp_want.lamp_on || out_data.fading !== lamp_want.fading) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: expected level %0d on %0b fading %0b, got level %0d on %0b fading %0b",
                     $time, lamp_want.compare_level, lamp_want.lamp_on, lamp_want.fading,
                     out_data.compare_level, out_data.lamp_on, out_data.fading);
        end
      end
      states_checked <= states_checked + 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_event(input logic tick, input logic press);
    in_t ev;
    ev.tick = tick;
    ev.press = press;
    remote_events.push_back(ev);
  endtask

  task automatic queue_random(input int n, input int tick_pct, input int press_pct);
    for (int i = 0; i < n; i++)
      push_event($urandom_range(99) < tick_pct, $urandom_range(99) < press_pct);
  endtask

  // Sampled at the falling edge, so the decision never races the clocked processes.
  task automatic wait_idle();
    do @(negedge clk);
    while (remote_events.size() != 0 || in_valid || lamp_states_due.size() != 0);
  endtask

  // One write transaction on the configuration port; the shadow copy follows at acceptance.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIMEOUT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MANUAL_STEP: manual_step = value[STEP_W-1:0];
      CFG_TIMED_STEP: timed_step = value[STEP_W-1:0];
      CFG_OFF_TIMEOUT: off_timeout = value;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Waits until the block is empty, reprogrammes all three registers and queues a random
  // stretch of events. The step registers are only 16 bits wide, so the upper data bits are
  // filled with noise that must be ignored.
  task automatic run_phase(input logic [STEP_W-1:0] manual, input logic [STEP_W-1:0] timed,
                           input logic [TIMEOUT_W-1:0] timeout, input int n,
                           input int tick_pct, input int press_pct);
    wait_idle();
    write_reg(CFG_MANUAL_STEP, {8'($urandom), manual});
    write_reg(CFG_TIMED_STEP, {8'($urandom), timed});
    write_reg(CFG_OFF_TIMEOUT, timeout);
    @(negedge clk);
    queue_random(n, tick_pct, press_pct);
  endtask

  initial begin
    manual_step = MANUAL_STEP_RST;
    timed_step = TIMED_STEP_RST;
    off_timeout = OFF_TIMEOUT_RST;
    lamp_level = 0;
    lamp_settled_on = 1'b1;
    fade_active = 1'b0;
    fade_to_off = 1'b0;
    fade_slow = 1'b0;
    elapsed_ms = '0;
    ms_counting = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed start at the reset configuration: idle and ticking while on (the counter is
    // not running yet), a press without a tick, then presses during the fade, with and
    // without a tick, which must be dropped.
    push_event(1'b0, 1'b0);
    push_event(1'b1, 1'b0);
    push_event(1'b1, 1'b0);
    push_event(1'b0, 1'b1);
    push_event(1'b1, 1'b1);
    push_event(1'b1, 1'b0);
    push_event(1'b1, 1'b0);
    push_event(1'b1, 1'b0);
    push_event(1'b0, 1'b0);
    push_event(1'b0, 1'b1);
    push_event(1'b1, 1'b0);

    // The spare index must leave every register as it was.
    wait_idle();
    write_reg(CFG_SPARE_INDEX, 24'($urandom));

    // Zero periods and a zero timeout: the level moves on every tick, and once the off-fade
    // ends the slow on-fade starts at once unless a press arrives on that very event.
    run_phase('0, '0, '0, 320, 95, 20);
    // Short timeout, so the counter crosses it exactly while the lamp is off.
    run_phase(16'd1, 16'd2, 24'd5, 200, 85, 8);
    // Largest settings: fades crawl and the timeout is never reached.
    run_phase({STEP_W{1'b1}}, {STEP_W{1'b1}}, {TIMEOUT_W{1'b1}}, 40, 90, 30);
    // Smallest nonzero settings, so the level moves on every tick of a fade.
    run_phase(16'd1, 16'd1, 24'd1, 200, 90, 5);
    run_phase(16'd2, 16'd1, '0, 100, 70, 10);

    // Everything accepted and every result checked once the wait ends; then the summary is printed.
    wait_idle();
    repeat (4) @(posedge clk);

    $display("Run covered %0d remote events and %0d checked lamp states with %0d register writes.",
             events_sent, states_checked, cfg_writes);
    $display("Fades seen: %0d started by a press and %0d started by the off timeout.",
             press_fades, timed_fades);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
